/* design/rlbm_pkg.sv */
// Shared types, constants and helpers for the RMS bar-graph level meter.
// No dependencies; rlbm_mac and the top level import this package.
package rlbm_pkg;

  localparam int SAMPLE_W       = 10;
  localparam int THR_W          = 10;
  localparam int LEVEL_W        = 4;
  localparam int MASK_W         = 8;
  localparam int NUM_REGS       = 8;
  localparam int REG_IDX_W      = 3;
  localparam int SQ_W           = 2 * SAMPLE_W;
  localparam int DEF_WINDOW_LEN = 50;
  localparam int DEF_BAR_COUNT  = 8;

  localparam logic [THR_W-1:0] THR_RESET [NUM_REGS] = '{
    10'd350, 10'd360, 10'd365, 10'd370, 10'd380, 10'd390, 10'd400, 10'd410
  };

  typedef enum logic [0:0] {
    OP_SAMPLE  = 1'b0,
    OP_REFRESH = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_BAR_SQ,
    ST_BAR_MUL,
    ST_BAR_CMP,
    ST_EMIT
  } state_t;

  // Control word from the sequencer to the shared multiply/accumulate unit
  typedef struct packed {
    logic acc_clr;  // clear the sum of squares
    logic sq_en;    // product <= sample * sample
    logic acc_en;   // sum += product
    logic thr_sq;   // product <= T * T
    logic thr_mul;  // product <= (product + 1) * WINDOW_LEN
  } mac_ctrl_t;

  // Low 'level' bits set
  function automatic logic [MASK_W-1:0] bar_mask(input logic [LEVEL_W-1:0] level);
    logic [MASK_W:0] ones;
    ones = (MASK_W+1)'(1) << level;
    return ones[MASK_W-1:0] - MASK_W'(1);
  endfunction

endpackage

/* design/rlbm_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rlbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/rlbm_mac.sv */
// Shared multiply/accumulate/compare unit of the level meter.
// Depends on rlbm_pkg (mac_ctrl_t, widths).
module rlbm_mac #(
  parameter int WINDOW_LEN = rlbm_pkg::DEF_WINDOW_LEN
) (
  input  logic                          clk,
  input  rlbm_pkg::mac_ctrl_t           ctrl,
  input  logic [rlbm_pkg::SAMPLE_W-1:0] smp,
  input  logic                          smp_zero,
  input  logic [rlbm_pkg::THR_W-1:0]    thr,
  output logic                          ge
);
  import rlbm_pkg::*;

  localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
  localparam int A_W    = SQ_W + 1;
  localparam int B_W    = (CNT_W > SAMPLE_W) ? CNT_W : SAMPLE_W;
  localparam int PROD_W = A_W + B_W;
  localparam int SUM_W  = SQ_W + CNT_W;
  localparam int CMP_W  = (SUM_W > PROD_W) ? SUM_W : PROD_W;

  logic [SAMPLE_W-1:0] smp_eff;
  logic [A_W-1:0]      a_op;
  logic [B_W-1:0]      b_op;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic                prod_en;
  logic [SUM_W-1:0]    acc_r;

  // unwritten window entries read as zero
  assign smp_eff = smp_zero ? '0 : smp;

  always_comb begin
    a_op    = '0;
    b_op    = '0;
    prod_en = 1'b1;
    priority if (ctrl.sq_en) begin
      a_op = A_W'(smp_eff);
      b_op = B_W'(smp_eff);
    end else if (ctrl.thr_sq) begin
      a_op = A_W'(thr);
      b_op = B_W'(thr);
    end else if (ctrl.thr_mul) begin
      // floor(sum/N) > T*T  <=>  sum >= N*(T*T + 1)
      a_op = A_W'(prod_r[SQ_W-1:0]) + A_W'(1);
      b_op = B_W'(WINDOW_LEN);
    end else begin
      prod_en = 1'b0;
    end
    prod_nxt = PROD_W'(a_op) * PROD_W'(b_op);
  end

  always_ff @(posedge clk) begin
    if (prod_en) begin
      prod_r <= prod_nxt;
    end
    if (ctrl.acc_clr) begin
      acc_r <= '0;
    end else if (ctrl.acc_en) begin
      acc_r <= acc_r + SUM_W'(prod_r[SQ_W-1:0]);
    end
  end

  assign ge = CMP_W'(acc_r) >= CMP_W'(prod_r);

endmodule

/* design/rms_level_bar_meter_core.sv */
// RMS bar-graph level meter, top level: sequencer, sample window, thresholds.
// Depends on rlbm_pkg, rlbm_ram and rlbm_mac.
// Sample word: one per cycle while idle, no result.
// Refresh word: walks the window through the one read port and the shared multiplier,
// then squares, scales and compares one threshold per bar (up to BAR_COUNT), then loads
// the output register if the level changed; no new word is taken meanwhile.
// Reset (rst_n low, synchronous): thresholds to defaults, level and pointers to zero;
// the window reads as zero through a fill count, so there is no clearing pass.
module rms_level_bar_meter_core #(
  parameter int WINDOW_LEN = rlbm_pkg::DEF_WINDOW_LEN,
  parameter int BAR_COUNT  = rlbm_pkg::DEF_BAR_COUNT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [15:0]                    in_tdata,   // [9:0] audio_sample
  input  logic                           in_tuser,   // [0] opcode
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [15:0]                    out_tdata,  // [3:0] bar_level, [11:4] lit_mask
  input  logic                           cfg_we,
  input  logic [rlbm_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [rlbm_pkg::THR_W-1:0]     cfg_data
);
  import rlbm_pkg::*;

  localparam int AW     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
  localparam int STEP_W = $clog2(WINDOW_LEN + 2);

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                v1_r, v1_nxt, v2_r, v2_nxt, z1_r, z1_nxt;
  logic [LEVEL_W-1:0]  lvl_r, lvl_nxt, last_level_r, last_level_nxt, lvl_fin;
  logic [AW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0]    fill_r, fill_nxt;
  logic [THR_W-1:0]    thr_r [NUM_REGS];
  logic                out_valid_r, out_valid_nxt, out_load;
  logic [LEVEL_W-1:0]  out_level_r;
  logic [MASK_W-1:0]   out_mask_r;

  logic                in_acc, ram_we, ram_re, ge;
  logic [SAMPLE_W-1:0] ram_rdata;
  mac_ctrl_t           ctrl;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_mask_r, out_level_r};

  always_comb begin
    state_nxt      = state_r;
    step_nxt       = step_r;
    lvl_nxt        = lvl_r;
    last_level_nxt = last_level_r;
    wr_ptr_nxt     = wr_ptr_r;
    fill_nxt       = fill_r;
    ctrl           = '0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    out_load       = 1'b0;
    lvl_fin        = ge ? lvl_r + LEVEL_W'(1) : lvl_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (op_t'(in_tuser) == OP_SAMPLE) begin
            ram_we     = 1'b1;
            wr_ptr_nxt = (wr_ptr_r == AW'(WINDOW_LEN - 1)) ? '0 : wr_ptr_r + AW'(1);
            if (fill_r != CNT_W'(WINDOW_LEN)) begin
              fill_nxt = fill_r + CNT_W'(1);
            end
          end else begin
            ctrl.acc_clr = 1'b1;
            step_nxt     = '0;
            lvl_nxt      = '0;
            state_nxt    = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        // read into the RAM output register, square into prod_r, then accumulate (v1_r, v2_r)
        ram_re      = step_r < STEP_W'(WINDOW_LEN);
        ctrl.sq_en  = v1_r;
        ctrl.acc_en = v2_r;
        step_nxt    = step_r + STEP_W'(1);
        if (step_r == STEP_W'(WINDOW_LEN + 1)) begin
          state_nxt = ST_BAR_SQ;
        end
      end
      ST_BAR_SQ: begin
        ctrl.thr_sq = 1'b1;
        state_nxt   = ST_BAR_MUL;
      end
      ST_BAR_MUL: begin
        ctrl.thr_mul = 1'b1;
        state_nxt    = ST_BAR_CMP;
      end
      ST_BAR_CMP: begin
        lvl_nxt = lvl_fin;
        if (ge && lvl_fin != LEVEL_W'(BAR_COUNT)) begin
          state_nxt = ST_BAR_SQ;
        end else if (lvl_fin != last_level_r) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_load       = 1'b1;
          last_level_nxt = lvl_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    v1_nxt        = ram_re;
    v2_nxt        = v1_r;
    z1_nxt        = step_r >= STEP_W'(fill_r);
    out_valid_nxt = out_load ? 1'b1 : (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_r       <= '0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      lvl_r        <= '0;
      last_level_r <= '0;
      wr_ptr_r     <= '0;
      fill_r       <= '0;
      out_valid_r  <= 1'b0;
      thr_r        <= THR_RESET;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      v1_r         <= v1_nxt;
      v2_r         <= v2_nxt;
      lvl_r        <= lvl_nxt;
      last_level_r <= last_level_nxt;
      wr_ptr_r     <= wr_ptr_nxt;
      fill_r       <= fill_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        thr_r[cfg_index] <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    z1_r <= z1_nxt;
    if (out_load) begin
      out_level_r <= lvl_r;
      out_mask_r  <= bar_mask(lvl_r);
    end
  end

  rlbm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_LEN)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr_r),
    .wdata (in_tdata[SAMPLE_W-1:0]),
    .re    (ram_re),
    .raddr (step_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  rlbm_mac #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_mac (
    .clk      (clk),
    .ctrl     (ctrl),
    .smp      (ram_rdata),
    .smp_zero (z1_r),
    .thr      (thr_r[lvl_r[REG_IDX_W-1:0]]),
    .ge       (ge)
  );

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(WINDOW_LEN))
    else $error("fill count beyond window length");

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wr_ptr_r <= AW'(WINDOW_LEN - 1))
    else $error("write pointer beyond window");

  a_lvl_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lvl_r <= LEVEL_W'(BAR_COUNT))
    else $error("level beyond bar count");

  a_emit_changed: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> lvl_r != last_level_r)
    else $error("result emitted for an unchanged level");

  a_busy_during_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r || v2_r) |-> state_r == ST_SUM)
    else $error("window read pipeline active outside the summing pass");
`endif

endmodule
